/* rtl/rri_pkg.sv */
// Shared types, constants and helpers for the RTCP report interval core.
// No dependencies; imported by every module of the block except the checker.
`default_nettype none

package rri_pkg;

  localparam int RANDOM_BITS = 16;

  localparam int NUM_W    = 44;
  localparam int DEN_W    = 34;
  localparam int T_W      = 34;
  localparam int SCALE_W  = 17;
  localparam int S_W      = 35;
  localparam int PROD_W   = 51;
  localparam int DIV_STAGES = NUM_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [11:0]        MS_X4          = 12'd4000;
  localparam logic [15:0]        COMP_RECIP_Q16 = 16'd53794;
  localparam logic [SCALE_W-1:0] HALF_Q16       = 17'd32768;

  localparam logic [1:0] CFG_BANDWIDTH    = 2'd0;
  localparam logic [1:0] CFG_MIN_INTERVAL = 2'd1;

  localparam logic [1:0] SHARE_SENDER   = 2'd0;
  localparam logic [1:0] SHARE_RECEIVER = 2'd1;
  localparam logic [1:0] SHARE_FULL     = 2'd2;

  typedef struct packed {
    logic [15:0]        avg;
    logic [15:0]        sites;
    logic [1:0]         share;
    logic [15:0]        minimum;
    logic [SCALE_W-1:0] scale;
  } rri_job_t;

  typedef struct packed {
    logic [15:0]        minimum;
    logic [SCALE_W-1:0] scale;
  } rri_side_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] den;
    rri_side_t        side;
  } rri_div_t;

  function automatic logic [15:0] to_q16(input logic [15:0] r);
    logic [31:0] wide;
    logic [31:0] masked;
    logic [15:0] res;
    wide = {16'b0, r};
    if (RANDOM_BITS >= 32) masked = wide;
    else masked = wide & ((32'd1 << RANDOM_BITS) - 32'd1);
    if (RANDOM_BITS > 16) res = masked[15:0] >> (RANDOM_BITS - 16);
    else res = 16'(masked << (16 - RANDOM_BITS));
    return res;
  endfunction

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic rri_div_t div_step(input rri_div_t x);
    rri_div_t         y;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    y = x;
    shifted = {x.rem, x.nq[NUM_W-1]};
    diff = shifted - {1'b0, x.den};
    if (shifted >= {1'b0, x.den}) begin
      y.rem = diff[DEN_W-1:0];
      y.nq  = {x.nq[NUM_W-2:0], 1'b1};
    end else begin
      y.rem = shifted[DEN_W-1:0];
      y.nq  = {x.nq[NUM_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

`default_nettype wire

/* rtl/rtcp_report_interval_core.sv */
// Top level of the RTCP report interval core: configuration registers and wiring.
// Depends on rri_pkg, rri_front, rri_queue and rri_back.
//
//   channel | dir | handshake            | payload
//   cfg     | in  | cfg_write            | cfg_index, cfg_data
//   in      | in  | in_valid / in_ready  | member_count .. random_fraction
//   out     | out | out_valid / out_ready | interval_ms, saturated
//
// One request per cycle sustained while the output is not stalled.
// The path runs through the queue, products, 44-stage divider, clamp, scaling and output register.
// rst is synchronous; it empties the 4-entry job queue and all stage valids.
// A stalled output freezes the whole arithmetic pipeline; the queue keeps
// taking input until it is full.
`default_nettype none

module rtcp_report_interval_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] member_count,
  input  logic [15:0] sender_count,
  input  logic        we_sent_flag,
  input  logic [15:0] average_packet_size,
  input  logic        initial_flag,
  input  logic [15:0] random_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] interval_ms,
  output logic        saturated
);
  import rri_pkg::*;

  logic [31:0] session_rtcp_bandwidth;
  logic [15:0] minimum_interval_ms;
  logic [31:0] bw_eff;

  logic     push;
  logic     pop;
  logic     queue_full;
  logic     queue_empty;
  rri_job_t push_job;
  rri_job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_rtcp_bandwidth <= 32'd1;
      minimum_interval_ms    <= 16'd5000;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BANDWIDTH:    session_rtcp_bandwidth <= cfg_data;
        CFG_MIN_INTERVAL: minimum_interval_ms    <= cfg_data[15:0];
        default:          ;
      endcase
    end
  end

  assign bw_eff = (session_rtcp_bandwidth == '0) ? 32'd1 : session_rtcp_bandwidth;

  rri_front u_front (
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .member_count        (member_count),
    .sender_count        (sender_count),
    .we_sent_flag        (we_sent_flag),
    .average_packet_size (average_packet_size),
    .initial_flag        (initial_flag),
    .random_fraction     (random_fraction),
    .minimum_interval_ms (minimum_interval_ms),
    .queue_full          (queue_full),
    .push                (push),
    .job                 (push_job)
  );

  rri_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head_job (head_job)
  );

  rri_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (!queue_empty),
    .job         (head_job),
    .pop         (pop),
    .bandwidth   (bw_eff),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .interval_ms (interval_ms),
    .saturated   (saturated)
  );

endmodule

`default_nettype wire

/* rtl/rri_front.sv */
// Front end: input handshake and classification of a request into a job.
// Depends on rri_pkg.
`default_nettype none

module rri_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      member_count,
  input  logic [15:0]      sender_count,
  input  logic             we_sent_flag,
  input  logic [15:0]      average_packet_size,
  input  logic             initial_flag,
  input  logic [15:0]      random_fraction,
  input  logic [15:0]      minimum_interval_ms,
  input  logic             queue_full,
  output logic             push,
  output rri_pkg::rri_job_t job
);
  import rri_pkg::*;

  logic [17:0] senders_x4;
  logic        split_share;

  assign in_ready    = !queue_full;
  assign push        = in_valid && !queue_full;
  assign senders_x4  = {sender_count, 2'b00};
  assign split_share = senders_x4 <= {2'b00, member_count};

  always_comb begin
    job.avg   = average_packet_size;
    job.scale = HALF_Q16 + {1'b0, to_q16(random_fraction)};
    if (initial_flag) job.minimum = {1'b0, minimum_interval_ms[15:1]};
    else job.minimum = minimum_interval_ms;
    if (!split_share) begin
      job.share = SHARE_FULL;
      job.sites = member_count;
    end else if (we_sent_flag) begin
      job.share = SHARE_SENDER;
      job.sites = sender_count;
    end else begin
      job.share = SHARE_RECEIVER;
      job.sites = member_count - sender_count;
    end
  end

endmodule

`default_nettype wire

/* rtl/rri_queue.sv */
// Short job queue between the front end and the arithmetic pipeline.
// Depends on rri_pkg.
`default_nettype none

module rri_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rri_pkg::rri_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output rri_pkg::rri_job_t head_job
);
  import rri_pkg::*;

  rri_job_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/rri_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, side data alongside.
// Depends on rri_pkg.
`default_nettype none

module rri_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [rri_pkg::NUM_W-1:0] num,
  input  logic [rri_pkg::DEN_W-1:0] den,
  input  rri_pkg::rri_side_t       in_side,
  output logic                     out_valid,
  output logic [rri_pkg::NUM_W-1:0] quot,
  output rri_pkg::rri_side_t       out_side
);
  import rri_pkg::*;

  rri_div_t stg [DIV_STAGES];
  logic     vld [DIV_STAGES];
  rri_div_t init;

  always_comb begin
    init.rem  = '0;
    init.nq   = num;
    init.den  = den;
    init.side = in_side;
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) stg[i] <= div_step(init);
      end
      always_ff @(posedge clk) begin
        if (rst) vld[i] <= 1'b0;
        else if (adv) vld[i] <= in_valid;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) stg[i] <= div_step(stg[i-1]);
      end
      always_ff @(posedge clk) begin
        if (rst) vld[i] <= 1'b0;
        else if (adv) vld[i] <= vld[i-1];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quot      = stg[DIV_STAGES-1].nq;
  assign out_side  = stg[DIV_STAGES-1].side;

endmodule

`default_nettype wire

/* rtl/rri_back.sv */
// Back end: products, division, clamp, random scaling, compensation, output register.
// Depends on rri_pkg and rri_divider.
`default_nettype none

module rri_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  rri_pkg::rri_job_t job,
  output logic              pop,
  input  logic [31:0]       bandwidth,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       interval_ms,
  output logic              saturated
);
  import rri_pkg::*;

  logic adv;

  logic             s1_v;
  logic [31:0]      s1_prod;
  logic [DEN_W-1:0] s1_den;
  rri_side_t        s1_side;
  logic [DEN_W-1:0] den_c;

  logic             s2_v;
  logic [NUM_W-1:0] s2_num;
  logic [DEN_W-1:0] s2_den;
  rri_side_t        s2_side;

  logic             d_v;
  logic [NUM_W-1:0] d_quot;
  rri_side_t        d_side;
  logic [T_W-1:0]   t_sat;
  logic [T_W-1:0]   t_c;

  logic               c_v;
  logic [T_W-1:0]     c_t;
  logic [SCALE_W-1:0] c_scale;

  logic [PROD_W-1:0] p1;
  logic              m1_v;
  logic [S_W-1:0]    m1_s;

  logic [PROD_W-1:0] p2;
  logic              m2_v;
  logic [S_W-1:0]    m2_u;

  assign adv = !out_valid || out_ready;
  assign pop = job_valid && adv;

  always_comb begin
    case (job.share)
      SHARE_SENDER:   den_c = {2'b00, bandwidth};
      SHARE_RECEIVER: den_c = {2'b00, bandwidth} + {1'b0, bandwidth, 1'b0};
      default:        den_c = {bandwidth, 2'b00};
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod         <= job.avg * job.sites;
      s1_den          <= den_c;
      s1_side.minimum <= job.minimum;
      s1_side.scale   <= job.scale;
      s2_num          <= {12'b0, s1_prod} * {32'b0, MS_X4};
      s2_den          <= s1_den;
      s2_side         <= s1_side;
      c_t             <= t_c;
      c_scale         <= d_side.scale;
      m1_s            <= p1[PROD_W-1:16];
      m2_u            <= p2[PROD_W-1:16];
      interval_ms     <= (|m2_u[S_W-1:32]) ? 32'hFFFF_FFFF : m2_u[31:0];
      saturated       <= |m2_u[S_W-1:32];
    end
  end

  rri_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s2_v),
    .num       (s2_num),
    .den       (s2_den),
    .in_side   (s2_side),
    .out_valid (d_v),
    .quot      (d_quot),
    .out_side  (d_side)
  );

  // quotients past 34 bits always saturate the output, so clip them here
  assign t_sat = (|d_quot[NUM_W-1:T_W]) ? '1 : d_quot[T_W-1:0];
  assign t_c   = (t_sat < {18'b0, d_side.minimum}) ? {18'b0, d_side.minimum} : t_sat;
  assign p1    = {17'b0, c_t} * {34'b0, c_scale};
  assign p2    = {16'b0, m1_s} * {35'b0, COMP_RECIP_Q16};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      c_v       <= 1'b0;
      m1_v      <= 1'b0;
      m2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= pop;
      s2_v      <= s1_v;
      c_v       <= d_v;
      m1_v      <= c_v;
      m2_v      <= m1_v;
      out_valid <= m2_v;
    end
  end

endmodule

`default_nettype wire

/* rtl/rri_checker.sv */
// Port-level checks for rtcp_report_interval_core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module rri_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] interval_ms,
  input logic        saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(interval_ms) && $stable(saturated))
    else $error("result changed while stalled");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> interval_ms == 32'hFFFF_FFFF)
    else $error("saturated flag without clamped interval");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_rst_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind rtcp_report_interval_core rri_checker u_rri_checker (.*);

`default_nettype wire
